// ===== rtl/itte_pkg.sv =====
`default_nettype none
package itte_pkg;

    localparam int YEAR_LIMIT    = 99999;
    localparam int YEAR_HARD_MAX = 262143;
    localparam int MAG_MAX       = 524287;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_T     = 8'h54;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    localparam logic signed [71:0] OUT_MAX = 72'sd4503599627370495;

    typedef struct packed {
        logic                valid_pre;
        logic signed [19:0]  year;
        logic signed [19:0]  month;
        logic signed [19:0]  day;
        logic signed [19:0]  hour;
        logic signed [19:0]  minute;
        logic signed [19:0]  second;
        logic [19:0]         frac;
    } rec_t;

    function automatic logic [7:0] sep_char(input logic [2:0] pos);
        logic [7:0] c;
        unique case (pos)
            3'd0, 3'd1: c = CHAR_MINUS;
            3'd2:       c = CHAR_T;
            default:    c = CHAR_COLON;
        endcase
        return c;
    endfunction

    function automatic logic [16:0] frac_weight(input logic [2:0] idx);
        logic [16:0] w;
        unique case (idx)
            3'd0:    w = 17'd100000;
            3'd1:    w = 17'd10000;
            3'd2:    w = 17'd1000;
            3'd3:    w = 17'd100;
            3'd4:    w = 17'd10;
            default: w = 17'd1;
        endcase
        return w;
    endfunction

    // day of year of the first of each month, March based
    function automatic logic [8:0] month_base(input logic [3:0] mp);
        logic [8:0] d;
        unique case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            default: d = 9'd337;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/itte_if.sv =====
`default_nettype none
interface itte_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       last_byte;
    modport source (output valid, text_byte, last_byte, input ready);
    modport sink (input valid, text_byte, last_byte, output ready);
endinterface

interface itte_out_if;
    logic               valid;
    logic               ready;
    logic               valid_res;
    logic signed [52:0] epoch_micros;
    modport source (output valid, valid_res, epoch_micros, input ready);
    modport sink (input valid, valid_res, epoch_micros, output ready);
endinterface
`default_nettype wire

// ===== rtl/itte_front.sv =====
`default_nettype none
module itte_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    itte_in_if.sink            text_in,
    input  wire logic          q_full,
    output logic               rec_push,
    output itte_pkg::rec_t     rec_data
);
    import itte_pkg::*;

    logic [2:0]         fp_reg, fp_next;
    logic               ds_reg, ds_next;
    logic               sn_reg, sn_next;
    logic               ss_reg, ss_next;
    logic [18:0]        acc_reg, acc_next;
    logic signed [19:0] fv_reg [6];
    logic signed [19:0] fv_next [6];
    logic               mf_reg, mf_next;
    logic               se_reg, se_next;
    logic               dot_reg, dot_next;
    logic               fo_reg, fo_next;
    logic [19:0]        facc_reg, facc_next;
    logic [2:0]         fcnt_reg, fcnt_next;

    logic [7:0]         b;
    logic               is_digit, is_blank, accept, fin_commit;
    logic [3:0]         dv;
    logic [22:0]        acc10;
    logic signed [19:0] cur_val, fin_val;

    assign b        = text_in.text_byte;
    assign is_digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    assign dv       = is_digit ? 4'(b - CHAR_ZERO) : 4'd0;
    assign is_blank = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    assign acc10    = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + {19'd0, dv};
    assign cur_val  = sn_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign accept   = text_in.valid && text_in.ready;
    assign text_in.ready = !q_full;

    always_comb
    begin
        fp_next   = fp_reg;
        ds_next   = ds_reg;
        sn_next   = sn_reg;
        ss_next   = ss_reg;
        acc_next  = acc_reg;
        fv_next   = fv_reg;
        mf_next   = mf_reg;
        se_next   = se_reg;
        dot_next  = dot_reg;
        fo_next   = fo_reg;
        facc_next = facc_reg;
        fcnt_next = fcnt_reg;
        if (!mf_reg && !se_reg && (fp_reg < 3'd6))
        begin
            if (ds_reg)
            begin
                if (is_digit)
                begin
                    acc_next = (acc10 > 23'(MAG_MAX)) ? 19'(MAG_MAX) : acc10[18:0];
                end
                else if ((fp_reg == 3'd5) || (b == sep_char(fp_reg)))
                begin
                    fv_next[fp_reg] = cur_val;
                    fp_next  = fp_reg + 3'd1;
                    ds_next  = 1'b0;
                    sn_next  = 1'b0;
                    ss_next  = 1'b0;
                    acc_next = '0;
                end
                else
                begin
                    mf_next = 1'b1;
                end
            end
            else if (!ss_reg && is_blank)
            begin
                ss_next = ss_reg;
            end
            else if (!ss_reg && ((b == CHAR_PLUS) || (b == CHAR_MINUS)))
            begin
                ss_next = 1'b1;
                sn_next = (b == CHAR_MINUS);
            end
            else if (is_digit)
            begin
                ds_next  = 1'b1;
                acc_next = {15'd0, dv};
            end
            else
            begin
                mf_next = 1'b1;
            end
        end
        if (b == 8'd0)
        begin
            se_next = 1'b1;
        end
        if (fo_reg)
        begin
            if (is_digit)
            begin
                if (fcnt_reg < 3'd6)
                begin
                    facc_next = facc_reg + 20'(dv) * 20'(frac_weight(fcnt_reg));
                    fcnt_next = fcnt_reg + 3'd1;
                end
            end
            else
            begin
                fo_next = 1'b0;
            end
        end
        else if (!dot_reg && (b == CHAR_DOT))
        begin
            dot_next = 1'b1;
            fo_next  = 1'b1;
        end
    end

    assign fin_commit = !mf_next && (fp_next == 3'd5) && ds_next;
    assign fin_val    = sn_next ? -$signed({1'b0, acc_next}) : $signed({1'b0, acc_next});

    always_comb
    begin
        rec_push           = accept && text_in.last_byte;
        rec_data.valid_pre = !mf_next && ((fp_next == 3'd6) || fin_commit);
        rec_data.year      = fv_next[0];
        rec_data.month     = fv_next[1];
        rec_data.day       = fv_next[2];
        rec_data.hour      = fv_next[3];
        rec_data.minute    = fv_next[4];
        rec_data.second    = fin_commit ? fin_val : fv_next[5];
        rec_data.frac      = facc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fp_reg   <= '0;
            ds_reg   <= 1'b0;
            sn_reg   <= 1'b0;
            ss_reg   <= 1'b0;
            acc_reg  <= '0;
            mf_reg   <= 1'b0;
            se_reg   <= 1'b0;
            dot_reg  <= 1'b0;
            fo_reg   <= 1'b0;
            facc_reg <= '0;
            fcnt_reg <= '0;
        end
        else if (accept)
        begin
            if (text_in.last_byte)
            begin
                fp_reg   <= '0;
                ds_reg   <= 1'b0;
                sn_reg   <= 1'b0;
                ss_reg   <= 1'b0;
                acc_reg  <= '0;
                mf_reg   <= 1'b0;
                se_reg   <= 1'b0;
                dot_reg  <= 1'b0;
                fo_reg   <= 1'b0;
                facc_reg <= '0;
                fcnt_reg <= '0;
            end
            else
            begin
                fp_reg   <= fp_next;
                ds_reg   <= ds_next;
                sn_reg   <= sn_next;
                ss_reg   <= ss_next;
                acc_reg  <= acc_next;
                mf_reg   <= mf_next;
                se_reg   <= se_next;
                dot_reg  <= dot_next;
                fo_reg   <= fo_next;
                facc_reg <= facc_next;
                fcnt_reg <= fcnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !text_in.last_byte)
        begin
            fv_reg <= fv_next;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/itte_queue.sv =====
`default_nettype none
module itte_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire itte_pkg::rec_t push_data,
    output logic                full,
    input  wire logic           pop,
    output logic                empty,
    output itte_pkg::rec_t      pop_data
);
    import itte_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    rec_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [PW:0]   cnt_reg;

    assign full     = (cnt_reg == (PW+1)'(QUEUE_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push && !full)
            begin
                wr_reg <= (wr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop && !empty)
            begin
                rd_reg <= (rd_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            mem_reg[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/itte_back.sv =====
`default_nettype none
module itte_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_empty,
    input  wire itte_pkg::rec_t q_data,
    output logic                q_pop,
    itte_out_if.source          result_out
);
    import itte_pkg::*;

    typedef enum logic [3:0] {
        B_IDLE, B_ERA, B_YOE, B_DOE, B_DAYS, B_SECS, B_MLO, B_MHI, B_SUM
    } bstate_t;

    bstate_t            state_reg;
    logic               ok_reg;
    logic               neg_reg;
    logic signed [20:0] yp_reg;
    logic [18:0]        a_reg;
    logic [9:0]         doy_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         min_reg, sec_reg;
    logic [19:0]        frac_reg;
    logic signed [10:0] era_reg;
    logic [8:0]         yoe_reg;
    logic [17:0]        doe_reg;
    logic signed [29:0] days_reg;
    logic signed [47:0] secs_reg;
    logic [42:0]        plo_reg;
    logic signed [44:0] phi_reg;
    logic               out_valid_reg, out_res_reg;
    logic signed [52:0] out_val_reg;

    logic               rng_ok, out_free;
    logic signed [20:0] yp_c, ymag;
    logic [3:0]         mp_c;
    logic [37:0]        qprod;
    logic [9:0]         q_c;
    logic signed [20:0] yoe_full;
    logic [15:0]        yoe41;
    logic signed [71:0] sum_c;

    assign ymag   = q_data.year < 0 ? -21'(q_data.year) : 21'(q_data.year);
    assign rng_ok = q_data.valid_pre
        && (q_data.month >= 20'sd1) && (q_data.month <= 20'sd12)
        && (q_data.day >= 20'sd1) && (q_data.day <= 20'sd31)
        && (q_data.hour >= 20'sd0) && (q_data.hour <= 20'sd23)
        && (q_data.minute >= 20'sd0) && (q_data.minute <= 20'sd59)
        && (q_data.second >= 20'sd0) && (q_data.second <= 20'sd60)
        && (ymag <= 21'(YEAR_LIMIT)) && (ymag <= 21'(YEAR_HARD_MAX));
    assign yp_c  = (q_data.month <= 20'sd2) ? 21'(q_data.year) - 21'sd1 : 21'(q_data.year);
    assign mp_c  = (q_data.month > 20'sd2) ? 4'(q_data.month - 20'sd3)
                                           : 4'(q_data.month + 20'sd9);
    assign qprod    = 38'(a_reg) * 38'd335545;
    assign q_c      = qprod[36:27];
    assign yoe_full = yp_reg - 21'(era_reg) * 21'sd400;
    assign yoe41    = 16'(yoe_reg) * 16'd41;
    assign sum_c    = (72'(phi_reg) <<< 23) + 72'(plo_reg) + 72'(frac_reg);
    assign out_free = !out_valid_reg || result_out.ready;
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    assign result_out.valid        = out_valid_reg;
    assign result_out.valid_res    = out_res_reg;
    assign result_out.epoch_micros = out_val_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
            out_res_reg   <= 1'b0;
            out_val_reg   <= '0;
        end
        else
        begin
            if (result_out.ready && (state_reg != B_SUM))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE:
                begin
                    if (!q_empty)
                    begin
                        ok_reg   <= rng_ok;
                        yp_reg   <= yp_c;
                        neg_reg  <= yp_c < 0;
                        a_reg    <= yp_c < 0 ? 19'(21'sd399 - yp_c) : 19'(yp_c);
                        doy_reg  <= 10'(month_base(mp_c)) + 10'(q_data.day[4:0]) - 10'd1;
                        hour_reg <= q_data.hour[4:0];
                        min_reg  <= q_data.minute[5:0];
                        sec_reg  <= q_data.second[5:0];
                        frac_reg <= q_data.frac;
                        state_reg <= B_ERA;
                    end
                end
                B_ERA:
                begin
                    era_reg   <= neg_reg ? -$signed({1'b0, q_c}) : $signed({1'b0, q_c});
                    state_reg <= B_YOE;
                end
                B_YOE:
                begin
                    yoe_reg   <= yoe_full[8:0];
                    state_reg <= B_DOE;
                end
                B_DOE:
                begin
                    doe_reg <= 18'(yoe_reg) * 18'd365 + 18'(yoe_reg[8:2])
                             - 18'(yoe41[15:12]) + 18'(doy_reg);
                    state_reg <= B_DAYS;
                end
                B_DAYS:
                begin
                    days_reg  <= 30'(era_reg) * 30'sd146097 + $signed({12'd0, doe_reg})
                               - 30'sd719468;
                    state_reg <= B_SECS;
                end
                B_SECS:
                begin
                    secs_reg <= 48'(days_reg) * 48'sd86400
                              + $signed(48'(hour_reg) * 48'd3600)
                              + $signed(48'(min_reg) * 48'd60) + $signed(48'(sec_reg));
                    state_reg <= B_MLO;
                end
                B_MLO:
                begin
                    plo_reg   <= 43'(secs_reg[22:0]) * 43'd1000000;
                    state_reg <= B_MHI;
                end
                B_MHI:
                begin
                    phi_reg   <= 45'($signed(secs_reg[47:23])) * 45'sd1000000;
                    state_reg <= B_SUM;
                end
                B_SUM:
                begin
                    if (out_free)
                    begin
                        if (!ok_reg)
                        begin
                            out_val_reg <= '0;
                        end
                        else if (sum_c > OUT_MAX)
                        begin
                            out_val_reg <= 53'(OUT_MAX);
                        end
                        else if (sum_c < -OUT_MAX)
                        begin
                            out_val_reg <= 53'(-OUT_MAX);
                        end
                        else
                        begin
                            out_val_reg <= sum_c[52:0];
                        end
                        out_res_reg   <= ok_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= B_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= B_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== rtl/iso_timestamp_to_epoch_micros.sv =====
// Parses ISO 8601 style timestamp text (year-month-dayThour:minute:second with an
// optional fraction after the first '.') one byte per cycle and returns, per record,
// a valid flag and signed microseconds since 1970. Bytes stream in at one per cycle;
// the record marked by last_byte goes through a two-entry queue to a calendar unit
// that steps through ERA, YOE, DOE, DAYS, SECS, MLO, MHI and SUM for each record and
// then holds its result until the previous one has been taken; it pops the next record
// only from IDLE. The byte side stalls only when the queue is full.
`default_nettype none
module iso_timestamp_to_epoch_micros (
    input  wire logic  clk,
    input  wire logic  rst_n,
    itte_in_if.sink    text_in,
    itte_out_if.source result_out
);
    import itte_pkg::*;

    logic rec_push, q_full, q_empty, q_pop;
    rec_t rec_data, q_data;

    itte_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in),
        .q_full   (q_full),
        .rec_push (rec_push),
        .rec_data (rec_data)
    );

    itte_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (rec_data),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_data)
    );

    itte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .result_out (result_out)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rec_push && q_full))
        else $error("queue overflow");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && !result_out.valid_res) |-> (result_out.epoch_micros == '0))
        else $error("invalid result not zero");

    a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        result_out.valid |-> (result_out.epoch_micros != {1'b1, 52'd0}))
        else $error("result outside clamp");

endmodule
`default_nettype wire
